/* design/persistence_qualified_thermostat_top_assert.svh */
// Assertion macros shared by the thermostat checker.
// CHK_ASSERT is gated by reset; CHK_ASSERT_RST also samples while reset is held.
`ifndef PERSISTENCE_QUALIFIED_THERMOSTAT_TOP_ASSERT_SVH
`define PERSISTENCE_QUALIFIED_THERMOSTAT_TOP_ASSERT_SVH

// Clocked property, disabled while reset is asserted
`define CHK_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Clocked property that is also checked during reset
`define CHK_ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* design/pqt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pqt_pkg
// Types, codes and reset values for the persistence-qualified thermostat.
// ----------------------------------------------------------------------------
package pqt_pkg;

	localparam int TEMP_W  = 16;
	localparam int COUNT_W = 8;
	localparam int CFG_W   = 16;
	localparam int IDX_W   = 3;

	// Controller phase
	typedef enum logic [1:0] {
		MODE_WATCH = 2'd0,
		MODE_HEAT  = 2'd1,
		MODE_COOL  = 2'd2
	} mode_t;

	// How a run ended
	typedef enum logic [2:0] {
		END_NONE      = 3'd0,
		END_NO_ACTION = 3'd1,
		END_HEATED    = 3'd2,
		END_COOLED    = 3'd3,
		END_FAILED    = 3'd4
	} run_end_t;

	// Per-sample decision
	typedef enum logic [2:0] {
		VERD_NONE    = 3'd0,
		VERD_LOW     = 3'd1,
		VERD_HIGH    = 3'd2,
		VERD_NORMAL  = 3'd3,
		VERD_TIMEOUT = 3'd4
	} verdict_t;

	// Configuration register indexes
	typedef enum logic [IDX_W-1:0] {
		REG_LOW_LIMIT   = 3'd0,
		REG_LOW_HOLD    = 3'd1,
		REG_HIGH_LIMIT  = 3'd2,
		REG_HIGH_HOLD   = 3'd3,
		REG_NORMAL_HOLD = 3'd4,
		REG_WINDOW_LEN  = 3'd5
	} reg_idx_t;

	// Reset values
	localparam logic signed [TEMP_W-1:0] RST_LOW_LIMIT   = 16'sd120;
	localparam logic        [COUNT_W-1:0] RST_LOW_HOLD   = 8'd5;
	localparam logic signed [TEMP_W-1:0] RST_HIGH_LIMIT  = 16'sd180;
	localparam logic        [COUNT_W-1:0] RST_HIGH_HOLD  = 8'd5;
	localparam logic        [COUNT_W-1:0] RST_NORMAL_HOLD = 8'd5;
	localparam logic        [COUNT_W-1:0] RST_WINDOW_LEN = 8'd60;

	// Saturating 8-bit increment
	function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] c);
		sat_inc = (c == {COUNT_W{1'b1}}) ? c : c + COUNT_W'(1);
	endfunction

endpackage

/* design/persistence_qualified_thermostat_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// persistence_qualified_thermostat_top
// Bang-bang thermostat with persistence qualification. Takes one signed
// temperature sample per transaction and returns one result per sample: the
// echoed sample, the four actuator drives, the phase after the sample and a
// run-end code. A sample is accepted every cycle as long as the output
// register is empty or being drained; its result is written into that register
// when the sample is accepted, so throughput is one sample per clock and is
// set only by the output handshake. Configuration is a plain write port and
// is expected to change only while the block is idle.
// ----------------------------------------------------------------------------
module persistence_qualified_thermostat_top
	import pqt_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	// sample channel
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic signed [TEMP_W-1:0]  sample,
	// result channel
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic signed [TEMP_W-1:0]  shown_temp,
	output logic                      compressor_on,
	output logic                      compressor_fan_on,
	output logic                      heater_on,
	output logic                      circulation_fan_on,
	output logic [1:0]                phase,
	output logic [2:0]                run_end,
	// configuration
	input  logic                      cfg_we,
	input  logic [IDX_W-1:0]          cfg_index,
	input  logic [CFG_W-1:0]          cfg_data
);

	// Configuration registers
	logic signed [TEMP_W-1:0]  low_limit_q, high_limit_q;
	logic [COUNT_W-1:0]        low_hold_q, high_hold_q, normal_hold_q, window_len_q;

	// Controller state
	mode_t                     mode_q;
	logic [COUNT_W-1:0]        cold_q, warm_q, inband_q, window_q;

	// Next-state and result logic
	logic                      accept;
	logic [COUNT_W-1:0]        win_len;
	logic [COUNT_W-1:0]        win_nx, cold_nx, warm_nx, inband_nx;
	verdict_t                  verdict;
	mode_t                     mode_nx;
	run_end_t                  end_nx;

	assign in_ready = !out_valid || out_ready;
	assign accept   = in_valid && in_ready;

	// Configuration writes; unused indexes are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_limit_q   <= RST_LOW_LIMIT;
			low_hold_q    <= RST_LOW_HOLD;
			high_limit_q  <= RST_HIGH_LIMIT;
			high_hold_q   <= RST_HIGH_HOLD;
			normal_hold_q <= RST_NORMAL_HOLD;
			window_len_q  <= RST_WINDOW_LEN;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LOW_LIMIT:   low_limit_q   <= cfg_data;
				REG_LOW_HOLD:    low_hold_q    <= cfg_data[COUNT_W-1:0];
				REG_HIGH_LIMIT:  high_limit_q  <= cfg_data;
				REG_HIGH_HOLD:   high_hold_q   <= cfg_data[COUNT_W-1:0];
				REG_NORMAL_HOLD: normal_hold_q <= cfg_data[COUNT_W-1:0];
				REG_WINDOW_LEN:  window_len_q  <= cfg_data[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Zero window length behaves as one sample
	assign win_len = (window_len_q == '0) ? COUNT_W'(1) : window_len_q;

	// Classify the sample and update the persistence counters
	always_comb begin
		win_nx    = sat_inc(window_q);
		cold_nx   = '0;
		warm_nx   = '0;
		inband_nx = inband_q;
		verdict   = VERD_NONE;
		if (sample < low_limit_q) begin
			cold_nx = sat_inc(cold_q);
			if (cold_nx > low_hold_q) verdict = VERD_LOW;
		end else if (sample > high_limit_q) begin
			warm_nx = sat_inc(warm_q);
			if (warm_nx > high_hold_q) verdict = VERD_HIGH;
		end else begin
			inband_nx = sat_inc(inband_q);
			if (inband_nx > normal_hold_q) verdict = VERD_NORMAL;
		end
		// timeout only when no decision was taken on this sample
		if (verdict == VERD_NONE && win_nx >= win_len) verdict = VERD_TIMEOUT;
	end

	// Phase transitions and run-end code
	always_comb begin
		mode_nx = mode_q;
		end_nx  = END_NONE;
		if (verdict != VERD_NONE) begin
			if (mode_q == MODE_WATCH) begin
				case (verdict)
					VERD_LOW:  mode_nx = MODE_HEAT;
					VERD_HIGH: mode_nx = MODE_COOL;
					default:   end_nx  = END_NO_ACTION;
				endcase
			end else begin
				if (verdict == VERD_NORMAL)
					end_nx = (mode_q == MODE_HEAT) ? END_HEATED : END_COOLED;
				else
					end_nx = END_FAILED;
				mode_nx = MODE_WATCH;
			end
		end
	end

	// Controller state; any verdict opens a fresh window
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_WATCH;
			cold_q   <= '0;
			warm_q   <= '0;
			inband_q <= '0;
			window_q <= '0;
		end else if (accept) begin
			mode_q <= mode_nx;
			if (verdict != VERD_NONE) begin
				cold_q   <= '0;
				warm_q   <= '0;
				inband_q <= '0;
				window_q <= '0;
			end else begin
				cold_q   <= cold_nx;
				warm_q   <= warm_nx;
				inband_q <= inband_nx;
				window_q <= win_nx;
			end
		end
	end

	// Output register: valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (accept) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	// Output register: payload
	always_ff @(posedge clk) begin
		if (accept) begin
			shown_temp         <= sample;
			compressor_on      <= (mode_nx == MODE_COOL);
			compressor_fan_on  <= (mode_nx == MODE_COOL);
			heater_on          <= (mode_nx == MODE_HEAT);
			circulation_fan_on <= (mode_nx != MODE_WATCH);
			phase              <= mode_nx;
			run_end            <= end_nx;
		end
	end

endmodule

/* design/pqt_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pqt_checker
// Port-level checks on the thermostat, bound to the top level.
// ----------------------------------------------------------------------------
`include "persistence_qualified_thermostat_top_assert.svh"

module pqt_checker
	import pqt_pkg::*;
(
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_ready,
	input logic signed [TEMP_W-1:0]  sample,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic signed [TEMP_W-1:0]  shown_temp,
	input logic                      compressor_on,
	input logic                      compressor_fan_on,
	input logic                      heater_on,
	input logic                      circulation_fan_on,
	input logic [1:0]                phase,
	input logic [2:0]                run_end
);

	// Actuator drives follow the reported phase
	`CHK_ASSERT(a_drives_match_phase, out_valid |-> (heater_on == (phase == MODE_HEAT)) && (compressor_on == (phase == MODE_COOL)) && (compressor_fan_on == compressor_on) && (circulation_fan_on == (phase != MODE_WATCH)), "actuators disagree with phase")

	// A finished run leaves everything off
	`CHK_ASSERT(a_end_is_idle, (out_valid && run_end != END_NONE) |-> (phase == MODE_WATCH) && !circulation_fan_on, "run ended with phase active")

	// Each accepted sample is echoed in the next result
	`CHK_ASSERT(a_echo, (in_valid && in_ready) |=> out_valid && (shown_temp == $past(sample)), "sample not echoed")

	// Stalled result holds
	`CHK_ASSERT(a_out_hold, (out_valid && !out_ready) |=> out_valid && $stable(shown_temp) && $stable(phase) && $stable(run_end), "stalled result changed")

	// No result while reset is held
	`CHK_ASSERT_RST(a_reset_quiet, !arst_n |-> !out_valid, "result valid during reset")

endmodule

bind persistence_qualified_thermostat_top pqt_checker u_pqt_checker (.*);
